// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file to check its own logic.
// Depends on nothing; each macro samples on the rising edge of clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/tcc_pkg.sv =====
// Shared types and constants of the terminal cursor controller.
// Used by the front, queue, back and top-level modules; depends on nothing.
package tcc_pkg;

   localparam int MAX_COLUMNS = 256;
   localparam int MAX_LINES   = 256;
   localparam int TAB_SHIFT   = 3;               // tab grid of 8 columns
   localparam int QUEUE_DEPTH = 2;               // power of two
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [8:0] COLUMNS_RESET      = 9'd80;
   localparam logic [8:0] LINES_RESET        = 9'd24;
   localparam logic [7:0] MARGIN_BOTTOM_RESET = 8'd23;
   localparam logic [7:0] MARGIN_RIGHT_RESET  = 8'd79;

   typedef enum logic [3:0] {
      OP_PRINT     = 4'd0,
      OP_LF        = 4'd1,
      OP_RI        = 4'd2,
      OP_CR        = 4'd3,
      OP_BS        = 4'd4,
      OP_MOVE      = 4'd5,
      OP_UP        = 4'd6,
      OP_DOWN      = 4'd7,
      OP_RIGHT     = 4'd8,
      OP_LEFT      = 4'd9,
      OP_FTAB      = 4'd10,
      OP_BTAB      = 4'd11,
      OP_TB_REGION = 4'd12,
      OP_LR_REGION = 4'd13,
      OP_SCREEN    = 4'd14,
      OP_NOP       = 4'd15
   } op_type;

   typedef enum logic [1:0] {
      CSR_COLUMNS  = 2'd0,
      CSR_LINES    = 2'd1,
      CSR_STATUS   = 2'd2,
      CSR_AUTOWRAP = 2'd3
   } csr_index_type;

   // Effective screen geometry after saturation.
   typedef struct packed {
      logic [8:0] cols;       // 1..256
      logic [8:0] lines;      // 1..256
      logic [7:0] last_col;   // cols - 1
      logic [7:0] last_row;   // last usable row, status line excluded
      logic       autowrap;
   } cfg_type;

   // One classified command as it waits in the queue.
   typedef struct packed {
      op_type      op;
      logic [20:0] code_point;
      logic [7:0]  arg_a;     // clamped column/top/left argument
      logic [7:0]  arg_b;     // clamped row/bottom/right argument
      logic [7:0]  step_count;
      logic        use_margins;
   } item_type;

   typedef struct packed {
      logic        insert_line_request;
      logic        scroll_up_request;
      logic [20:0] cell_write_char;
      logic [7:0]  cell_write_row;
      logic [7:0]  cell_write_col;
      logic        cell_write_valid;
      logic [7:0]  cursor_row;
      logic [7:0]  cursor_col;
   } result_type;

   typedef struct packed {
      logic [7:0] top;
      logic [7:0] bottom;
      logic [7:0] left;
      logic [7:0] right;
   } margins_type;

   typedef struct packed {
      logic                valid;
      logic                full;
      logic [QUEUE_AW:0]   count;
   } queue_status_type;

endpackage

// ===== rtl/tcc_front.sv =====
// Front end: takes command transfers and clamps their coordinate arguments.
// Depends on tcc_pkg; feeds tcc_queue.
module tcc_front (
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [47:0]        req_tdata,
   input  logic [3:0]         req_tuser,
   input  tcc_pkg::cfg_type   cfg,
   input  logic               queue_full,
   output logic               push,
   output tcc_pkg::item_type  item
);

   tcc_pkg::op_type  op;
   logic signed [8:0] arg_x;
   logic signed [8:0] arg_y;
   logic [7:0]        limit_a;
   logic [7:0]        limit_b;

   function automatic logic [7:0] clamp_arg(input logic signed [8:0] v, input logic [7:0] hi);
      logic [7:0] r;
      if (v < 0) begin
         r = 8'd0;
      end else if (v[7:0] > hi) begin
         r = hi;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

   assign op    = tcc_pkg::op_type'(req_tuser);
   assign arg_x = $signed(req_tdata[29:21]);
   assign arg_y = $signed(req_tdata[38:30]);

   // Column and left/right margin arguments clamp to columns, others to rows.
   assign limit_a = (op == tcc_pkg::OP_TB_REGION) ? cfg.last_row : cfg.last_col;
   assign limit_b = (op == tcc_pkg::OP_LR_REGION) ? cfg.last_col : cfg.last_row;

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   assign item.op          = op;
   assign item.code_point  = req_tdata[20:0];
   assign item.arg_a       = clamp_arg(arg_x, limit_a);
   assign item.arg_b       = clamp_arg(arg_y, limit_b);
   assign item.step_count  = req_tdata[46:39];
   assign item.use_margins = req_tdata[47];

endmodule

// ===== rtl/tcc_queue.sv =====
// Short FIFO of classified commands between the front and back ends.
// Depends on tcc_pkg for the item type and depth.
module tcc_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  tcc_pkg::item_type          push_item,
   input  logic                       pop,
   output tcc_pkg::item_type          pop_item,
   output tcc_pkg::queue_status_type  status
);

   tcc_pkg::item_type              slot_ff [tcc_pkg::QUEUE_DEPTH];
   logic [tcc_pkg::QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [tcc_pkg::QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [tcc_pkg::QUEUE_AW:0]     count_ff, count_in;

   // Pointers wrap on their own because the depth is a power of two.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (tcc_pkg::QUEUE_AW+1)'(push) - (tcc_pkg::QUEUE_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item     = slot_ff[rd_ptr_ff];
   assign status.valid = (count_ff != '0);
   assign status.full  = (count_ff == (tcc_pkg::QUEUE_AW+1)'(tcc_pkg::QUEUE_DEPTH));
   assign status.count = count_ff;

endmodule

// ===== rtl/tcc_back.sv =====
// Back end: holds cursor and margins, executes one command per cycle while the result
// register is empty or drains, and registers the result. Depends on tcc_pkg; pops items from tcc_queue.
module tcc_back (
   input  logic                       clock,
   input  logic                       reset,
   input  tcc_pkg::cfg_type           cfg,
   input  logic                       item_valid,
   input  tcc_pkg::item_type          item,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output tcc_pkg::result_type        rsp_result,
   output tcc_pkg::margins_type       margins
);

   logic [7:0]          col_ff, col_in, row_ff, row_in;
   logic [7:0]          mt_ff, mt_in, mb_ff, mb_in, ml_ff, ml_in, mr_ff, mr_in;
   logic                out_valid_ff, out_valid_in;
   tcc_pkg::result_type out_ff, out_in;

   logic [7:0]          ex_col, ex_row, ex_mt, ex_mb, ex_ml, ex_mr;
   logic                ex_scroll, ex_insert, ex_write;
   logic [7:0]          step;

   logic [8:0]          col_plus1;
   logic                print_wrap;
   logic                at_bottom;
   logic [7:0]          row_plus1;
   logic [9:0]          up_diff, lt_diff;
   logic [7:0]          up_bound, lt_bound, dn_bound, rt_bound;
   logic [8:0]          dn_sum, rt_sum;
   logic [8:0]          ft_cell;
   logic [11:0]         ft_col;
   logic [7:0]          bt_xm1, bt_nm1;
   logic [4:0]          bt_k, bt_left;

   assign step      = item.step_count;
   assign col_plus1 = {1'b0, col_ff} + 9'd1;
   assign print_wrap = col_plus1 >= cfg.cols;
   assign at_bottom = row_ff >= mb_ff;
   assign row_plus1 = row_ff + 8'd1;

   assign up_bound = item.use_margins ? mt_ff : 8'd0;
   assign up_diff  = {2'b00, row_ff} - {2'b00, step};
   assign dn_bound = item.use_margins ? mb_ff : cfg.last_row;
   assign dn_sum   = {1'b0, row_ff} + {1'b0, step};
   assign rt_bound = item.use_margins ? mr_ff : cfg.last_col;
   assign rt_sum   = {1'b0, col_ff} + {1'b0, step};
   assign lt_bound = item.use_margins ? ml_ff : 8'd0;
   assign lt_diff  = {2'b00, col_ff} - {2'b00, step};

   // Forward tab: next grid stop n times over, capped at the last column.
   assign ft_cell = {4'b0000, col_ff[7:3]} + {1'b0, step};
   assign ft_col  = {ft_cell, 3'b000};

   // Backward tab: the first step lands on the stop below, every further
   // step goes back one full grid cell, stopping at column zero.
   assign bt_xm1  = col_ff - 8'd1;
   assign bt_k    = bt_xm1[7:tcc_pkg::TAB_SHIFT];
   assign bt_nm1  = step - 8'd1;
   assign bt_left = bt_k - bt_nm1[4:0];

   always_comb begin
      ex_col    = col_ff;
      ex_row    = row_ff;
      ex_mt     = mt_ff;
      ex_mb     = mb_ff;
      ex_ml     = ml_ff;
      ex_mr     = mr_ff;
      ex_scroll = 1'b0;
      ex_insert = 1'b0;
      ex_write  = 1'b0;
      unique case (item.op)
         tcc_pkg::OP_PRINT: begin
            ex_write = ({1'b0, col_ff} < cfg.cols) && ({1'b0, row_ff} < cfg.lines);
            if (print_wrap) begin
               if (cfg.autowrap) begin
                  ex_col = ml_ff;
                  if (at_bottom) begin
                     ex_scroll = 1'b1;
                  end else begin
                     ex_row = row_plus1;
                  end
               end else begin
                  ex_col = cfg.last_col;
               end
            end else begin
               ex_col = col_plus1[7:0];
            end
         end
         tcc_pkg::OP_LF: begin
            if (at_bottom) begin
               ex_scroll = 1'b1;
            end else begin
               ex_row = row_plus1;
            end
         end
         tcc_pkg::OP_RI: begin
            if (row_ff <= mt_ff) begin
               ex_insert = 1'b1;
            end else begin
               ex_row = row_ff - 8'd1;
            end
         end
         tcc_pkg::OP_CR: begin
            ex_col = ml_ff;
         end
         tcc_pkg::OP_BS: begin
            if (col_ff > ml_ff) begin
               ex_col = col_ff - 8'd1;
            end
         end
         tcc_pkg::OP_MOVE: begin
            ex_col = item.arg_a;
            ex_row = item.arg_b;
         end
         tcc_pkg::OP_UP: begin
            ex_row = ($signed(up_diff) < $signed({2'b00, up_bound})) ? up_bound : up_diff[7:0];
         end
         tcc_pkg::OP_DOWN: begin
            ex_row = (dn_sum > {1'b0, dn_bound}) ? dn_bound : dn_sum[7:0];
         end
         tcc_pkg::OP_RIGHT: begin
            ex_col = (rt_sum > {1'b0, rt_bound}) ? rt_bound : rt_sum[7:0];
         end
         tcc_pkg::OP_LEFT: begin
            ex_col = ($signed(lt_diff) < $signed({2'b00, lt_bound})) ? lt_bound : lt_diff[7:0];
         end
         tcc_pkg::OP_FTAB: begin
            if (step != 8'd0) begin
               ex_col = (ft_col >= {3'b000, cfg.cols}) ? cfg.last_col : ft_col[7:0];
            end
         end
         tcc_pkg::OP_BTAB: begin
            if (step != 8'd0 && col_ff != 8'd0) begin
               ex_col = ({3'b000, bt_k} <= bt_nm1) ? 8'd0 : {bt_left, 3'b000};
            end
         end
         tcc_pkg::OP_TB_REGION: begin
            if (item.arg_a <= item.arg_b) begin
               ex_mt = item.arg_a;
               ex_mb = item.arg_b;
            end
         end
         tcc_pkg::OP_LR_REGION: begin
            if (item.arg_a <= item.arg_b) begin
               ex_ml = item.arg_a;
               ex_mr = item.arg_b;
            end
         end
         tcc_pkg::OP_SCREEN: begin
            ex_col = 8'd0;
            ex_row = 8'd0;
         end
         default: begin
         end
      endcase
   end

   // A new command enters whenever the result register is empty or drains.
   assign pop = item_valid && (!out_valid_ff || rsp_ready);

   always_comb begin
      col_in = pop ? ex_col : col_ff;
      row_in = pop ? ex_row : row_ff;
      mt_in  = pop ? ex_mt : mt_ff;
      mb_in  = pop ? ex_mb : mb_ff;
      ml_in  = pop ? ex_ml : ml_ff;
      mr_in  = pop ? ex_mr : mr_ff;
      out_valid_in = pop || (out_valid_ff && !rsp_ready);

      out_in                     = out_ff;
      if (pop) begin
         out_in.cursor_col          = ex_col;
         out_in.cursor_row          = ex_row;
         out_in.cell_write_valid    = ex_write;
         out_in.cell_write_col      = ex_write ? col_ff : 8'd0;
         out_in.cell_write_row      = ex_write ? row_ff : 8'd0;
         out_in.cell_write_char     = ex_write ? item.code_point : 21'd0;
         out_in.scroll_up_request   = ex_scroll;
         out_in.insert_line_request = ex_insert;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= 8'd0;
         row_ff       <= 8'd0;
         mt_ff        <= 8'd0;
         mb_ff        <= tcc_pkg::MARGIN_BOTTOM_RESET;
         ml_ff        <= 8'd0;
         mr_ff        <= tcc_pkg::MARGIN_RIGHT_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         mt_ff        <= mt_in;
         mb_ff        <= mb_in;
         ml_ff        <= ml_in;
         mr_ff        <= mr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_result     = out_ff;
   assign margins.top    = mt_ff;
   assign margins.bottom = mb_ff;
   assign margins.left   = ml_ff;
   assign margins.right  = mr_ff;

endmodule

// ===== rtl/terminal_cursor_controller.sv =====
// Top level of the terminal cursor controller: configuration registers,
// front end, command queue and back end. Depends on tcc_pkg and assert_macros.svh.
//
//  Port group | Direction | Contents
//  req_*      | in        | one cursor command per transfer
//  rsp_*      | out       | one cursor result per command
//  csr_*      | in        | screen geometry and autowrap writes
//
// A new command is accepted every cycle while the queue is not full; rsp_tvalid
// rises once the command has passed the queue and reached the result register.
// The two-entry queue lets the front accept while a result waits on rsp_tready.
// Synchronous reset homes the cursor, restores the default margins and
// loads 80 columns, 24 lines, no status line and autowrap on.
`include "assert_macros.svh"

module terminal_cursor_controller (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: code_point[20:0], arg_x[29:21], arg_y[38:30],
   //            step_count[46:39], use_margins[47]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,
   // req_tuser: opcode[3:0]
   input  logic [3:0]  req_tuser,
   // rsp_tdata: cursor_col[7:0], cursor_row[15:8], cell_write_valid[16],
   //            cell_write_col[24:17], cell_write_row[32:25],
   //            cell_write_char[53:33], scroll_up_request[54],
   //            insert_line_request[55]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_wdata
);

   logic [8:0]                  columns_ff, columns_in;
   logic [8:0]                  lines_ff, lines_in;
   logic                        status_ff, status_in;
   logic                        autowrap_ff, autowrap_in;
   logic [9:0]                  last_row_wide;

   tcc_pkg::cfg_type            cfg;
   tcc_pkg::item_type           push_item;
   tcc_pkg::item_type           pop_item;
   tcc_pkg::queue_status_type   q_status;
   tcc_pkg::result_type         result;
   tcc_pkg::margins_type        margins;
   logic                        push;
   logic                        pop;

   always_comb begin
      columns_in  = columns_ff;
      lines_in    = lines_ff;
      status_in   = status_ff;
      autowrap_in = autowrap_ff;
      if (csr_we) begin
         unique case (tcc_pkg::csr_index_type'(csr_index))
            tcc_pkg::CSR_COLUMNS:  columns_in  = csr_wdata;
            tcc_pkg::CSR_LINES:    lines_in    = csr_wdata;
            tcc_pkg::CSR_STATUS:   status_in   = csr_wdata[0];
            tcc_pkg::CSR_AUTOWRAP: autowrap_in = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff  <= tcc_pkg::COLUMNS_RESET;
         lines_ff    <= tcc_pkg::LINES_RESET;
         status_ff   <= 1'b0;
         autowrap_ff <= 1'b1;
      end else begin
         columns_ff  <= columns_in;
         lines_ff    <= lines_in;
         status_ff   <= status_in;
         autowrap_ff <= autowrap_in;
      end
   end

   // Register values outside the legal range saturate to 1..MAX.
   always_comb begin
      if (columns_ff == 9'd0) begin
         cfg.cols = 9'd1;
      end else if (columns_ff > 9'(tcc_pkg::MAX_COLUMNS)) begin
         cfg.cols = 9'(tcc_pkg::MAX_COLUMNS);
      end else begin
         cfg.cols = columns_ff;
      end
      if (lines_ff == 9'd0) begin
         cfg.lines = 9'd1;
      end else if (lines_ff > 9'(tcc_pkg::MAX_LINES)) begin
         cfg.lines = 9'(tcc_pkg::MAX_LINES);
      end else begin
         cfg.lines = lines_ff;
      end
      cfg.last_col  = 8'(cfg.cols - 9'd1);
      last_row_wide = {1'b0, cfg.lines} - {9'd0, status_ff} - 10'd1;
      // A status line that fills the screen leaves row zero usable.
      cfg.last_row  = last_row_wide[9] ? 8'd0 : last_row_wide[7:0];
      cfg.autowrap  = autowrap_ff;
   end

   tcc_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cfg        (cfg),
      .queue_full (q_status.full),
      .push       (push),
      .item       (push_item)
   );

   tcc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   tcc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (q_status.valid),
      .item       (pop_item),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result),
      .margins    (margins)
   );

   assign rsp_tdata = result;

   `ASSERT_ALWAYS(a_margins_ordered, (margins.top <= margins.bottom) && (margins.left <= margins.right), "margin pair out of order")
   `ASSERT_ALWAYS(a_queue_bound, q_status.count <= (tcc_pkg::QUEUE_AW+1)'(tcc_pkg::QUEUE_DEPTH), "command queue overflow")
   `ASSERT_IMPLY(a_no_write_zero, rsp_tvalid && !result.cell_write_valid, (result.cell_write_col == 8'd0) && (result.cell_write_row == 8'd0) && (result.cell_write_char == 21'd0), "cell fields set without a write")
   `ASSERT_IMPLY(a_one_request, rsp_tvalid, !(result.scroll_up_request && result.insert_line_request), "scroll and insert requested together")

endmodule
